FILE: rtl/mips_pkg.sv
// mips_pkg: shared types, opcode and event codes for the mips32 execute unit
// no dependencies
package mips_pkg;

    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW = $clog2(DMEM_WORDS);

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_PRINT_INT = 3'd1,
        EV_PRINT_CHR = 3'd2,
        EV_PRINT_HEX = 3'd3,
        EV_EXIT      = 3'd4,
        EV_UNSUP     = 3'd5
    } event_t;

    localparam logic [1:0] FMT_R = 2'd0;
    localparam logic [1:0] FMT_I = 2'd1;
    localparam logic [1:0] FMT_J = 2'd2;

    // r-type funct codes
    localparam logic [5:0] F_SLL = 6'd0, F_SRL = 6'd2, F_SRA = 6'd3, F_SLLV = 6'd4;
    localparam logic [5:0] F_SRLV = 6'd6, F_SRAV = 6'd7, F_JR = 6'd8, F_SYSCALL = 6'd12;
    localparam logic [5:0] F_ADD = 6'd32, F_ADDU = 6'd33, F_SUB = 6'd34, F_SUBU = 6'd35;
    localparam logic [5:0] F_AND = 6'd36, F_OR = 6'd37, F_XOR = 6'd38, F_NOR = 6'd39;
    localparam logic [5:0] F_SLT = 6'd42, F_SLTU = 6'd43;

    // i/j-type opcodes
    localparam logic [5:0] OP_REGIMM = 6'd1, OP_J = 6'd2, OP_JAL = 6'd3, OP_BEQ = 6'd4;
    localparam logic [5:0] OP_BNE = 6'd5, OP_ADDI = 6'd8, OP_ADDIU = 6'd9, OP_SLTI = 6'd10;
    localparam logic [5:0] OP_ANDI = 6'd12, OP_ORI = 6'd13, OP_XORI = 6'd14, OP_LUI = 6'd15;
    localparam logic [5:0] OP_LB = 6'd32, OP_LW = 6'd35, OP_LBU = 6'd36, OP_SB = 6'd40;
    localparam logic [5:0] OP_SW = 6'd43;

    // syscall services
    localparam logic [31:0] SYS_PRINT_INT = 32'd1, SYS_EXIT = 32'd10;
    localparam logic [31:0] SYS_PRINT_CHR = 32'd11, SYS_PRINT_HEX = 32'd34;

    // decoded request passed from the read stage to the execute stage
    typedef struct packed {
        logic [31:0] instr;
        logic [1:0]  format;
        logic [5:0]  func;
    } req_t;

    // register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

    // data memory write port
    typedef struct packed {
        logic               en;
        logic [DMEM_AW-1:0] addr;
        logic [31:0]        data;
    } dm_wr_t;

endpackage

FILE: rtl/mips_regfile.sv
// mips_regfile: 32 x 32 register file, three synchronous read ports, one write port
// depends on mips_pkg; write-through forwarding for same-cycle write and read
module mips_regfile (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [4:0]      ra0,
    input  logic [4:0]      ra1,
    input  logic [4:0]      ra2,
    input  mips_pkg::rf_wr_t wr,
    output logic [31:0]     rd0,
    output logic [31:0]     rd1,
    output logic [31:0]     rd2
);
    import mips_pkg::*;

    logic [31:0] regs_reg [32];

    // flops with reset clear, so reset value is all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 32; i++) regs_reg[i] <= '0;
        end else if (wr.en && wr.addr != 5'd0) begin
            regs_reg[wr.addr] <= wr.data;
        end
    end

    function automatic logic [31:0] rd_fwd(input logic [4:0] a, input rf_wr_t w,
                                           input logic [31:0] q);
        if (a == 5'd0) return '0;
        if (w.en && w.addr == a) return w.data;
        return q;
    endfunction

    // registered read with write forwarding
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd0 <= rd_fwd(ra0, wr, regs_reg[ra0]);
            rd1 <= rd_fwd(ra1, wr, regs_reg[ra1]);
            rd2 <= rd_fwd(ra2, wr, regs_reg[ra2]);
        end
    end
endmodule

FILE: rtl/mips_dmem.sv
// mips_dmem: word data memory, one synchronous read and one write port
// depends on mips_pkg; zero after reset via a clearing pass
module mips_dmem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [mips_pkg::DMEM_AW-1:0] raddr,
    input  mips_pkg::dm_wr_t           wr,
    output logic [31:0]                rdata,
    output logic                       clr_busy
);
    import mips_pkg::*;

    logic [31:0]        mem [DMEM_WORDS];
    logic [DMEM_AW-1:0] clr_reg;
    logic               busy_reg;

    // clearing pass after reset, one word a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + DMEM_AW'(1);
            if (clr_reg == DMEM_AW'(DMEM_WORDS - 1)) busy_reg <= 1'b0;
        end
    end

    assign clr_busy = busy_reg;

    // write port shared with the clearing pass
    always_ff @(posedge clk)
    begin
        if (busy_reg) mem[clr_reg] <= '0;
        else if (wr.en) mem[wr.addr] <= wr.data;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en) rdata <= mem[raddr];
    end
endmodule

FILE: rtl/mips32_execute_unit.sv
// mips32_execute_unit: top level, two-stage execute pipeline over register file and memory
// depends on mips_pkg, mips_regfile, mips_dmem
//
// Usage:
//   requests (instr, format, func) enter on in_valid/in_ready; results (next_pc,
//   event_res, event_value, halted) leave on out_valid/out_ready, one per request, in
//   order. start_pc_we/start_pc_wdata load the reset vector into the program counter;
//   write only while no request is in flight.
//   A request is accepted into stage 2 together with its register reads; it executes
//   and registers its result once the output slot is free or being taken. lb, lbu,
//   lw and sb first wait in stage 2 for the data word before they execute.
//   Throughput is one request per cycle while no lb, lbu, lw or sb waits for its
//   data word, no interlock holds and the receiver takes results. A request waits
//   while the request executing in stage 2 writes a register it reads (v0 is always
//   read), is a store, or is the exit syscall.
//   After reset the data memory is cleared over all DMEM_WORDS (1024) words; in_ready
//   stays low during that pass. When the receiver stalls, the output register holds,
//   stage 2 can still take one request, and then in_ready drops.
//   After the exit syscall every later request returns the held PC and halted = 1.
module mips32_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start_pc_we,
    input  logic [31:0] start_pc_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr,
    input  logic [1:0]  format,
    input  logic [5:0]  func,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic [2:0]  event_res,
    output logic [31:0] event_value,
    output logic        halted
);
    import mips_pkg::*;

    logic        s2_valid_reg, s2_valid_next;
    req_t        s2_req_reg;
    logic        out_valid_reg;
    logic [31:0] pc_reg, pc_next;
    logic        halt_reg, halt_next;
    logic [31:0] npc_reg;
    event_t      ev_reg;
    logic [31:0] evv_reg;
    logic        hlt_reg;

    rf_wr_t      rf_wr;
    dm_wr_t      dm_wr;
    logic [31:0] a, b;
    logic [31:0] a0, v0;
    logic [31:0] dword;
    logic        clr_busy;

    // syscall needs v0 and a0; read v0 on port 2 always and a0 on port 1 when format R syscall
    logic        in_sys;
    logic [4:0]  ra0, ra1, ra2;
    logic [DMEM_AW-1:0] in_waddr;
    logic        s2_adv, in_fire, hazard;

    assign in_sys = (format == FMT_R) && (func == F_SYSCALL);
    assign ra0 = instr[25:21];
    assign ra1 = in_sys ? 5'd4 : instr[20:16];
    assign ra2 = 5'd2;

    // stage 2 drains when output slot is free or being taken
    assign s2_adv = !out_valid_reg || out_ready;

    // interlock: the request executing in stage 2 writes a register this request
    // reads, stores to memory, or halts
    always_comb
    begin
        hazard = 1'b0;
        if (s2_valid_reg) begin
            if (rf_wr.en && rf_wr.addr != 5'd0 &&
                (rf_wr.addr == ra0 || rf_wr.addr == ra1 || rf_wr.addr == ra2))
                hazard = 1'b1;
            if (dm_wr.en) hazard = 1'b1;
            if (halt_next != halt_reg) hazard = 1'b1;
        end
    end

    // take a request when stage 2 is empty or its request leaves this cycle
    assign in_ready = !clr_busy && (!s2_valid_reg || exec) && !hazard;
    assign in_fire  = in_valid && in_ready;

    mips_regfile u_rf (
        .clk(clk), .rst_n(rst_n), .rd_en(in_fire),
        .ra0(ra0), .ra1(ra1), .ra2(ra2), .wr(rf_wr),
        .rd0(a), .rd1(b), .rd2(v0)
    );
    assign a0 = b;

    // data memory address from rs plus the sign-extended immediate, formed in stage 2
    logic [31:0] addr;
    logic [31:0] simm, zimm;
    assign zimm = {16'd0, s2_req_reg.instr[15:0]};
    assign simm = {{16{s2_req_reg.instr[15]}}, s2_req_reg.instr[15:0]};
    assign addr = a + simm;

    // lb, lbu, lw and sb wait in stage 2 for the data word
    logic        ld_wait_reg;
    logic        is_ld, is_st;
    assign is_ld = s2_req_reg.format == FMT_I &&
                   (s2_req_reg.func == OP_LB || s2_req_reg.func == OP_LBU ||
                    s2_req_reg.func == OP_LW || s2_req_reg.func == OP_SB);
    assign is_st = s2_req_reg.format == FMT_I &&
                   (s2_req_reg.func == OP_SB || s2_req_reg.func == OP_SW);
    assign in_waddr = addr[DMEM_AW+1:2];

    mips_dmem u_dm (
        .clk(clk), .rst_n(rst_n), .rd_en(1'b1), .raddr(in_waddr),
        .wr(dm_wr), .rdata(dword), .clr_busy(clr_busy)
    );

    // execute: word read is ready when ld_wait_reg is set
    logic        exec;
    event_t      ev;
    logic [31:0] evv, npc, pc4, btgt, res;
    logic [7:0]  by;
    logic [4:0]  sh, sa;
    logic [4:0]  rt, rd;
    logic        wen;
    logic [4:0]  waddr;
    logic [31:0] lane_mask;

    assign exec = s2_valid_reg && (!is_ld || ld_wait_reg || halt_reg) && s2_adv;

    always_comb
    begin
        pc4 = pc_reg + 32'd4;
        btgt = pc4 + {simm[29:0], 2'b00};
        npc = pc4;
        ev = EV_NONE;
        evv = '0;
        res = '0;
        wen = 1'b0;
        rt = s2_req_reg.instr[20:16];
        rd = s2_req_reg.instr[15:11];
        waddr = rd;
        sh = s2_req_reg.instr[10:6];
        sa = a[4:0];
        by = 8'(dword >> {addr[1:0], 3'b000});
        lane_mask = 32'hff << {addr[1:0], 3'b000};
        halt_next = halt_reg;
        dm_wr.en = 1'b0;
        dm_wr.addr = in_waddr;
        dm_wr.data = b;
        if (halt_reg) begin
            npc = pc_reg;
        end else begin
            case (s2_req_reg.format)
                FMT_R:
                begin
                    wen = 1'b1;
                    case (s2_req_reg.func)
                        F_ADD, F_ADDU: res = a + b;
                        F_SUB, F_SUBU: res = a - b;
                        F_AND: res = a & b;
                        F_OR:  res = a | b;
                        F_XOR: res = a ^ b;
                        F_NOR: res = ~(a | b);
                        F_SLT: res = {31'd0, $signed(a) < $signed(b)};
                        F_SLTU: res = {31'd0, a < b};
                        F_SLL: res = b << sh;
                        F_SRL: res = b >> sh;
                        F_SRA: res = 32'($signed(b) >>> sh);
                        F_SLLV: res = b << sa;
                        F_SRLV: res = b >> sa;
                        F_SRAV: res = 32'($signed(b) >>> sa);
                        F_JR:
                        begin
                            wen = 1'b0;
                            npc = a;
                        end
                        F_SYSCALL:
                        begin
                            wen = 1'b0;
                            if (v0 == SYS_PRINT_INT) begin ev = EV_PRINT_INT; evv = a0; end
                            else if (v0 == SYS_PRINT_CHR) begin ev = EV_PRINT_CHR; evv = a0; end
                            else if (v0 == SYS_PRINT_HEX) begin ev = EV_PRINT_HEX; evv = a0; end
                            else if (v0 == SYS_EXIT) begin ev = EV_EXIT; halt_next = 1'b1; end
                            else ev = EV_UNSUP;
                        end
                        default:
                        begin
                            wen = 1'b0;
                            ev = EV_UNSUP;
                        end
                    endcase
                end
                FMT_I:
                begin
                    waddr = rt;
                    wen = 1'b1;
                    case (s2_req_reg.func)
                        OP_LB: res = {{24{by[7]}}, by};
                        OP_LBU: res = {24'd0, by};
                        OP_LW: res = dword;
                        OP_SB:
                        begin
                            wen = 1'b0;
                            dm_wr.en = 1'b1;
                            dm_wr.data = (dword & ~lane_mask) |
                                         ({24'd0, b[7:0]} << {addr[1:0], 3'b000});
                        end
                        OP_SW:
                        begin
                            wen = 1'b0;
                            dm_wr.en = 1'b1;
                        end
                        OP_ADDI, OP_ADDIU: res = a + simm;
                        OP_SLTI: res = {31'd0, $signed(a) < $signed(simm)};
                        OP_ANDI: res = a & zimm;
                        OP_ORI:  res = a | zimm;
                        OP_XORI: res = a ^ zimm;
                        OP_LUI:  res = {s2_req_reg.instr[15:0], 16'd0};
                        OP_REGIMM:
                        begin
                            wen = 1'b0;
                            if (rt != 5'd0) ev = EV_UNSUP;
                            else if (a[31]) npc = btgt;
                        end
                        OP_BEQ:
                        begin
                            wen = 1'b0;
                            if (a == b) npc = btgt;
                        end
                        OP_BNE:
                        begin
                            wen = 1'b0;
                            if (a != b) npc = btgt;
                        end
                        default:
                        begin
                            wen = 1'b0;
                            ev = EV_UNSUP;
                        end
                    endcase
                end
                FMT_J:
                begin
                    if (s2_req_reg.func == OP_J || s2_req_reg.func == OP_JAL) begin
                        npc = {pc4[31:28], s2_req_reg.instr[25:0], 2'b00};
                        if (s2_req_reg.func == OP_JAL) begin
                            wen = 1'b1;
                            waddr = 5'd31;
                            res = pc4;
                        end
                    end else begin
                        ev = EV_UNSUP;
                    end
                end
                default: ev = EV_UNSUP;
            endcase
        end
        if (!exec) begin
            wen = 1'b0;
            dm_wr.en = 1'b0;
            halt_next = halt_reg;
        end
        rf_wr.en = wen;
        rf_wr.addr = waddr;
        rf_wr.data = res;
    end

    assign pc_next = exec ? npc : pc_reg;
    assign s2_valid_next = in_fire ? 1'b1 : (exec ? 1'b0 : s2_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            ld_wait_reg   <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
            halt_reg     <= halt_next;
            if (start_pc_we) pc_reg <= start_pc_wdata;
            else pc_reg <= pc_next;
            if (exec) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            // ld_wait_reg marks that the data word has come back from the registered read
            if (exec) ld_wait_reg <= 1'b0;
            else if (s2_valid_reg && is_ld && !halt_reg) ld_wait_reg <= 1'b1;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire) s2_req_reg <= '{instr: instr, format: format, func: func};
        if (exec) begin
            npc_reg <= npc;
            ev_reg  <= ev;
            evv_reg <= evv;
            hlt_reg <= halt_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = npc_reg;
    assign event_res   = ev_reg;
    assign event_value = evv_reg;
    assign halted      = hlt_reg;
endmodule
